>>> sv/i2cm_pkg.sv
// Shared types, codes and constants for the I2C master byte engine.
package i2cm_pkg;

    localparam int BYTE_BITS = 8;

    localparam int TICK_W  = 16;
    localparam int POLL_W  = 10;
    localparam int UNIT_W  = 3;
    localparam int BIT_W   = 4;
    localparam int CFG_W   = 16;

    // Configuration register indexes
    localparam logic CFG_TICKS_PER_UNIT = 1'b0;
    localparam logic CFG_ACK_POLL_LIMIT = 1'b1;

    localparam logic [TICK_W-1:0] TICKS_PER_UNIT_RST = 16'd100;
    localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RST = 10'd250;

    // Command codes
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_STOP      = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_READ_ACK  = 3'd4;
    localparam logic [2:0] OP_READ_NACK = 3'd5;

    // Phase lengths in timing units
    localparam logic [UNIT_W-1:0] UNITS_COND    = 3'd4;
    localparam logic [UNIT_W-1:0] UNITS_BIT     = 3'd1;
    localparam logic [UNIT_W-1:0] UNITS_ACK_CLK = 3'd2;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
        PH_WR_SET, PH_WR_HI, PH_WR_LO, PH_ACK_REL, PH_ACK_HI, PH_ACK_POLL,
        PH_RD_LO, PH_RD_HI, PH_MA_DRV, PH_MA_CLK
    } phase_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       timed_out;
    } out_t;

    typedef struct packed {
        logic              count_en;
        logic              restart;
        logic [UNIT_W-1:0] units;
    } timer_ctrl_t;

endpackage

>>> sv/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: register ports, request and result stages.
//
// Each request on the s_ channel is one clock tick of the I2C bus sequencer. It
// carries the sampled SDA level and, while the engine is idle, an optional
// command (start, stop, write byte, read byte with ACK or NACK). Commands that
// arrive while a command is in progress are dropped. Each request yields
// exactly one result on the m_ channel: the SCL/SDA release levels after that
// tick, busy and done, the last received byte and the acknowledge/timeout flags.
// A request accepted into the input register passes through the sequencer
// logic, which loads its result into the result register when the sequencer
// advances; the result is then offered on the m_ channel.
// Throughput: one request per cycle while results are taken; the sequencer state
// advances once per request in a single pass of logic.
// Backpressure: when m_ready is low the result register holds, the input
// register holds its request, and s_ready drops once both are full.
// Reset (aresetn low, synchronous): both stages empty, bus lines released,
// flags cleared, ticks_per_unit = 100, ack_poll_limit = 250.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0 ticks_per_unit, 1 ack_poll_limit); write only while no request is in flight.
module i2c_master_byte_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [i2cm_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  i2cm_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output i2cm_pkg::out_t                m_data
);
    import i2cm_pkg::*;

    logic [TICK_W-1:0] ticks_per_unit_reg;
    logic [POLL_W-1:0] ack_poll_limit_reg;
    logic              in_valid_reg;
    in_t               in_data_reg;
    logic              out_valid_reg;
    out_t              out_data_reg;
    out_t              seq_res;
    logic              adv;

    // Advance the sequencer when a request is held and the result slot frees up
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_unit_reg <= TICKS_PER_UNIT_RST;
            ack_poll_limit_reg <= ACK_POLL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TICKS_PER_UNIT: ticks_per_unit_reg <= cfg_wdata;
                CFG_ACK_POLL_LIMIT: ack_poll_limit_reg <= cfg_wdata[POLL_W-1:0];
                default: ;
            endcase
        end
    end

    // Request stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    i2cm_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .adv            (adv),
        .item           (in_data_reg),
        .ticks_per_unit (ticks_per_unit_reg),
        .ack_poll_limit (ack_poll_limit_reg),
        .res            (seq_res)
    );

    // Result stage: load on advance, drop the valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= seq_res;
        end
    end

endmodule

>>> sv/i2cm_timer.sv
// Tick and unit counter that times each pin phase but idle and ACK polling.
module i2cm_timer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  i2cm_pkg::timer_ctrl_t      ctrl,
    input  logic [15:0]                ticks_per_unit,
    output logic                       expired
);
    import i2cm_pkg::*;

    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [UNIT_W-1:0] unit_count_reg, unit_count_next;
    logic [TICK_W-1:0] tpu_eff;
    logic [TICK_W:0]   tick_inc;
    logic              wrap;
    logic [UNIT_W-1:0] unit_inc;

    // A zero setting counts as one tick per unit
    assign tpu_eff  = (ticks_per_unit == '0) ? TICK_W'(1) : ticks_per_unit;
    assign tick_inc = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
    assign wrap     = tick_inc >= {1'b0, tpu_eff};
    assign unit_inc = unit_count_reg + UNIT_W'(wrap);
    assign expired  = unit_inc >= ctrl.units;

    always_comb begin
        tick_count_next = tick_count_reg;
        unit_count_next = unit_count_reg;
        if (ctrl.restart) begin
            tick_count_next = '0;
            unit_count_next = '0;
        end else if (ctrl.count_en) begin
            tick_count_next = wrap ? '0 : tick_inc[TICK_W-1:0];
            unit_count_next = unit_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            unit_count_reg <= '0;
        end else begin
            tick_count_reg <= tick_count_next;
            unit_count_reg <= unit_count_next;
        end
    end

endmodule

>>> sv/i2cm_seq.sv
// Phase sequencer and byte datapath: one tick of bus activity per request.
module i2cm_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  i2cm_pkg::in_t         item,
    input  logic [15:0]           ticks_per_unit,
    input  logic [9:0]            ack_poll_limit,
    output i2cm_pkg::out_t        res
);
    import i2cm_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BIT_W-1:0]  bit_index_reg, bit_index_next;
    logic [7:0]        shift_reg, shift_next;
    logic [POLL_W-1:0] poll_count_reg, poll_count_next;
    logic              scl_level_reg, scl_level_next;
    logic              sda_level_reg, sda_level_next;
    logic [7:0]        rx_hold_reg, rx_hold_next;
    logic              ack_flag_reg, ack_flag_next;
    logic              timeout_flag_reg, timeout_flag_next;
    logic              send_ack_reg, send_ack_next;
    logic              done;
    logic              expired;
    logic [BIT_W-1:0]  bit_inc;
    logic              more_bits;
    logic              poll_over;
    timer_ctrl_t       tmr_ctrl;

    assign bit_inc   = bit_index_reg + BIT_W'(1);
    assign more_bits = bit_inc < BIT_W'(BYTE_BITS);
    assign poll_over = poll_count_reg >= ack_poll_limit;

    // Timer runs in every timed phase and restarts on each phase change
    always_comb begin
        tmr_ctrl.count_en = adv && (phase_reg != PH_IDLE) && (phase_reg != PH_ACK_POLL);
        tmr_ctrl.restart  = adv && (phase_next != phase_reg);
        case (phase_reg)
            PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: tmr_ctrl.units = UNITS_COND;
            PH_MA_CLK: tmr_ctrl.units = send_ack_reg ? UNITS_ACK_CLK : UNITS_BIT;
            default:   tmr_ctrl.units = UNITS_BIT;
        endcase
    end

    i2cm_timer u_timer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (tmr_ctrl),
        .ticks_per_unit (ticks_per_unit),
        .expired        (expired)
    );

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                case (item.op)
                    OP_START:                  phase_next = PH_ST_A;
                    OP_STOP:                   phase_next = PH_SP_A;
                    OP_WRITE:                  phase_next = PH_WR_SET;
                    OP_READ_ACK, OP_READ_NACK: phase_next = PH_RD_LO;
                    default:                   phase_next = PH_IDLE;
                endcase
            end
            PH_ST_A:    if (expired) phase_next = PH_ST_B;
            PH_ST_B:    if (expired) phase_next = PH_IDLE;
            PH_SP_A:    if (expired) phase_next = PH_SP_B;
            PH_SP_B:    if (expired) phase_next = PH_IDLE;
            PH_WR_SET:  if (expired) phase_next = PH_WR_HI;
            PH_WR_HI:   if (expired) phase_next = PH_WR_LO;
            PH_WR_LO:   if (expired) phase_next = more_bits ? PH_WR_SET : PH_ACK_REL;
            PH_ACK_REL: if (expired) phase_next = PH_ACK_HI;
            PH_ACK_HI:  if (expired) phase_next = PH_ACK_POLL;
            PH_ACK_POLL: begin
                if (!item.sda_in) phase_next = PH_IDLE;
                else if (poll_over) phase_next = PH_SP_A;
            end
            PH_RD_LO:   if (expired) phase_next = PH_RD_HI;
            PH_RD_HI:   if (expired) phase_next = more_bits ? PH_RD_LO : PH_MA_DRV;
            PH_MA_DRV:  if (expired) phase_next = PH_MA_CLK;
            PH_MA_CLK:  if (expired) phase_next = PH_IDLE;
            default:    phase_next = PH_IDLE;
        endcase
    end

    // Pin levels, shifter, flags
    always_comb begin
        bit_index_next    = bit_index_reg;
        shift_next        = shift_reg;
        poll_count_next   = poll_count_reg;
        scl_level_next    = scl_level_reg;
        sda_level_next    = sda_level_reg;
        rx_hold_next      = rx_hold_reg;
        ack_flag_next     = ack_flag_reg;
        timeout_flag_next = timeout_flag_reg;
        send_ack_next     = send_ack_reg;
        done              = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                case (item.op)
                    OP_START: begin
                        scl_level_next = 1'b1;
                        sda_level_next = 1'b1;
                    end
                    OP_STOP: begin
                        scl_level_next = 1'b0;
                        sda_level_next = 1'b0;
                    end
                    OP_WRITE: begin
                        ack_flag_next     = 1'b0;
                        timeout_flag_next = 1'b0;
                        shift_next        = item.tx_byte;
                        bit_index_next    = '0;
                        scl_level_next    = 1'b0;
                        sda_level_next    = item.tx_byte[BYTE_BITS-1];
                    end
                    OP_READ_ACK, OP_READ_NACK: begin
                        send_ack_next  = (item.op == OP_READ_ACK);
                        shift_next     = '0;
                        bit_index_next = '0;
                        scl_level_next = 1'b0;
                        sda_level_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            PH_ST_A: if (expired) begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b0;
            end
            PH_ST_B: if (expired) begin
                scl_level_next = 1'b0;
                sda_level_next = 1'b0;
                done           = 1'b1;
            end
            PH_SP_A: if (expired) begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b1;
            end
            PH_SP_B: if (expired) begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b1;
                done           = 1'b1;
            end
            PH_WR_SET:  if (expired) scl_level_next = 1'b1;
            PH_WR_HI:   if (expired) scl_level_next = 1'b0;
            PH_WR_LO: if (expired) begin
                shift_next     = {shift_reg[6:0], 1'b0};
                bit_index_next = bit_inc;
                scl_level_next = 1'b0;
                sda_level_next = more_bits ? shift_reg[6] : 1'b1;
            end
            PH_ACK_REL: if (expired) begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b1;
            end
            PH_ACK_HI:  if (expired) poll_count_next = '0;
            PH_ACK_POLL: begin
                if (!item.sda_in) begin
                    ack_flag_next  = 1'b1;
                    scl_level_next = 1'b0;
                    sda_level_next = 1'b1;
                    done           = 1'b1;
                end else if (poll_over) begin
                    // No acknowledge: flag it and issue a stop
                    timeout_flag_next = 1'b1;
                    scl_level_next    = 1'b0;
                    sda_level_next    = 1'b0;
                end else begin
                    poll_count_next = poll_count_reg + POLL_W'(1);
                end
            end
            PH_RD_LO: if (expired) begin
                scl_level_next = 1'b1;
                sda_level_next = 1'b1;
                shift_next     = {shift_reg[6:0], item.sda_in};
            end
            PH_RD_HI: if (expired) begin
                bit_index_next = bit_inc;
                scl_level_next = 1'b0;
                if (more_bits) begin
                    sda_level_next = 1'b1;
                end else begin
                    rx_hold_next   = shift_reg;
                    sda_level_next = !send_ack_reg;
                end
            end
            PH_MA_DRV:  if (expired) scl_level_next = 1'b1;
            PH_MA_CLK: if (expired) begin
                scl_level_next = 1'b0;
                done           = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        res.scl_release = scl_level_next;
        res.sda_release = sda_level_next;
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = done;
        res.rx_byte     = rx_hold_next;
        res.ack_seen    = ack_flag_next;
        res.timed_out   = timeout_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_index_reg    <= '0;
            shift_reg        <= '0;
            poll_count_reg   <= '0;
            scl_level_reg    <= 1'b1;
            sda_level_reg    <= 1'b1;
            rx_hold_reg      <= '0;
            ack_flag_reg     <= 1'b0;
            timeout_flag_reg <= 1'b0;
            send_ack_reg     <= 1'b0;
        end else if (adv) begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            shift_reg        <= shift_next;
            poll_count_reg   <= poll_count_next;
            scl_level_reg    <= scl_level_next;
            sda_level_reg    <= sda_level_next;
            rx_hold_reg      <= rx_hold_next;
            ack_flag_reg     <= ack_flag_next;
            timeout_flag_reg <= timeout_flag_next;
            send_ack_reg     <= send_ack_next;
        end
    end

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(phase_reg) && $stable(shift_reg))
        else $error("sequencer state moved without a request");

    a_write_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && phase_reg == PH_IDLE && item.op == OP_WRITE
        |=> phase_reg == PH_WR_SET && !ack_flag_reg && !timeout_flag_reg)
        else $error("write request did not start a bit with cleared flags");

    a_bit_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_index_reg <= BIT_W'(BYTE_BITS))
        else $error("bit index ran past the byte");

    a_scl_low_on_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_WR_SET || phase_reg == PH_RD_LO |-> !scl_level_reg)
        else $error("SCL released during data setup");

endmodule

>>> bench/i2cm_bus_checker.sv
// Checker for the I2C master byte engine: tracks configuration, predicts each result and compares.
`timescale 1ns / 100ps
module i2cm_bus_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  i2cm_pkg::in_t     s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  i2cm_pkg::out_t    m_data,
    output int                mismatches,
    output int                outstanding,
    output i2cm_pkg::phase_t  bus_phase
);
    import i2cm_pkg::*;

    localparam int SHOW_MAX = 60;

    logic [TICK_W-1:0] tpu_cfg;
    logic [POLL_W-1:0] poll_cfg;

    phase_t            ph;
    logic [TICK_W-1:0] tick_cnt;
    logic [UNIT_W-1:0] unit_cnt;
    logic [BIT_W-1:0]  bit_idx;
    logic [7:0]        shreg;
    logic [7:0]        rx_q;
    logic [POLL_W-1:0] poll_cnt;
    logic              scl_q, sda_q, ack_q, tmo_q, mack_q;

    out_t              pin_queue[$];
    int                shown;

    assign bus_phase = ph;

    function automatic void enter_phase(phase_t p, logic scl, logic sda);
        ph       = p;
        scl_q    = scl;
        sda_q    = sda;
        tick_cnt = '0;
        unit_cnt = '0;
    endfunction

    // Count one tick; true once the phase has lasted the given number of units.
    function automatic logic units_done(logic [UNIT_W-1:0] units);
        logic [TICK_W-1:0] span;
        span = (tpu_cfg == '0) ? 16'd1 : tpu_cfg;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= span) begin
            tick_cnt = '0;
            unit_cnt = unit_cnt + 3'd1;
        end
        return unit_cnt >= units;
    endfunction

    function automatic out_t step_bus(in_t req);
        logic fin;
        out_t res;
        fin = 1'b0;
        case (ph)
            PH_IDLE: begin
                case (req.op)
                    OP_START: enter_phase(PH_ST_A, 1'b1, 1'b1);
                    OP_STOP:  enter_phase(PH_SP_A, 1'b0, 1'b0);
                    OP_WRITE: begin
                        ack_q   = 1'b0;
                        tmo_q   = 1'b0;
                        shreg   = req.tx_byte;
                        bit_idx = '0;
                        enter_phase(PH_WR_SET, 1'b0, req.tx_byte[7]);
                    end
                    OP_READ_ACK, OP_READ_NACK: begin
                        mack_q  = (req.op == OP_READ_ACK);
                        shreg   = '0;
                        bit_idx = '0;
                        enter_phase(PH_RD_LO, 1'b0, 1'b1);
                    end
                    default: ;
                endcase
            end
            PH_ST_A: if (units_done(UNITS_COND)) enter_phase(PH_ST_B, 1'b1, 1'b0);
            PH_ST_B: if (units_done(UNITS_COND)) begin
                enter_phase(PH_IDLE, 1'b0, 1'b0);
                fin = 1'b1;
            end
            PH_SP_A: if (units_done(UNITS_COND)) enter_phase(PH_SP_B, 1'b1, 1'b1);
            PH_SP_B: if (units_done(UNITS_COND)) begin
                enter_phase(PH_IDLE, 1'b1, 1'b1);
                fin = 1'b1;
            end
            PH_WR_SET: if (units_done(UNITS_BIT)) enter_phase(PH_WR_HI, 1'b1, sda_q);
            PH_WR_HI:  if (units_done(UNITS_BIT)) enter_phase(PH_WR_LO, 1'b0, sda_q);
            PH_WR_LO: if (units_done(UNITS_BIT)) begin
                shreg   = shreg << 1;
                bit_idx = bit_idx + 4'd1;
                if (bit_idx < BYTE_BITS) enter_phase(PH_WR_SET, 1'b0, shreg[7]);
                else enter_phase(PH_ACK_REL, 1'b0, 1'b1);
            end
            PH_ACK_REL: if (units_done(UNITS_BIT)) enter_phase(PH_ACK_HI, 1'b1, 1'b1);
            PH_ACK_HI: if (units_done(UNITS_BIT)) begin
                poll_cnt = '0;
                enter_phase(PH_ACK_POLL, 1'b1, 1'b1);
            end
            PH_ACK_POLL: begin
                if (!req.sda_in) begin
                    ack_q = 1'b1;
                    enter_phase(PH_IDLE, 1'b0, 1'b1);
                    fin = 1'b1;
                end else if (poll_cnt >= poll_cfg) begin
                    tmo_q = 1'b1;
                    enter_phase(PH_SP_A, 1'b0, 1'b0);
                end else begin
                    poll_cnt = poll_cnt + 10'd1;
                end
            end
            PH_RD_LO: if (units_done(UNITS_BIT)) begin
                enter_phase(PH_RD_HI, 1'b1, 1'b1);
                shreg = {shreg[6:0], req.sda_in};
            end
            PH_RD_HI: if (units_done(UNITS_BIT)) begin
                bit_idx = bit_idx + 4'd1;
                if (bit_idx < BYTE_BITS) begin
                    enter_phase(PH_RD_LO, 1'b0, 1'b1);
                end else begin
                    rx_q = shreg;
                    enter_phase(PH_MA_DRV, 1'b0, !mack_q);
                end
            end
            PH_MA_DRV: if (units_done(UNITS_BIT)) enter_phase(PH_MA_CLK, 1'b1, sda_q);
            PH_MA_CLK: if (units_done(mack_q ? UNITS_ACK_CLK : UNITS_BIT)) begin
                enter_phase(PH_IDLE, 1'b0, sda_q);
                fin = 1'b1;
            end
            default: enter_phase(PH_IDLE, scl_q, sda_q);
        endcase
        res.scl_release = scl_q;
        res.sda_release = sda_q;
        res.busy_res    = (ph != PH_IDLE);
        res.done_res    = fin;
        res.rx_byte     = rx_q;
        res.ack_seen    = ack_q;
        res.timed_out   = tmo_q;
        return res;
    endfunction

    task automatic check_field(string fname, int want, int got);
        if (want != got) begin
            mismatches++;
            if (shown < SHOW_MAX)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, fname, want, got);
            shown++;
        end
    endtask

    always @(posedge aclk) begin
        out_t want_res;
        if (!aresetn) begin
            tpu_cfg  = TICKS_PER_UNIT_RST;
            poll_cfg = ACK_POLL_LIMIT_RST;
            ph       = PH_IDLE;
            tick_cnt = '0;
            unit_cnt = '0;
            bit_idx  = '0;
            shreg    = '0;
            poll_cnt = '0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            rx_q     = '0;
            ack_q    = 1'b0;
            tmo_q    = 1'b0;
            mack_q   = 1'b0;
            pin_queue.delete();
            mismatches = 0;
            shown      = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pin_queue.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result with nothing expected, actual %0h",
                             $time, m_data);
                end else begin
                    want_res = pin_queue.pop_front();
                    check_field("scl_release", want_res.scl_release, m_data.scl_release);
                    check_field("sda_release", want_res.sda_release, m_data.sda_release);
                    check_field("busy_res", want_res.busy_res, m_data.busy_res);
                    check_field("done_res", want_res.done_res, m_data.done_res);
                    check_field("rx_byte", want_res.rx_byte, m_data.rx_byte);
                    check_field("ack_seen", want_res.ack_seen, m_data.ack_seen);
                    check_field("timed_out", want_res.timed_out, m_data.timed_out);
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_TICKS_PER_UNIT) tpu_cfg = cfg_wdata;
                else poll_cfg = cfg_wdata[POLL_W-1:0];
            end
            if (s_valid && s_ready) pin_queue.push_back(step_bus(s_data));
        end
        outstanding = pin_queue.size();
    end

endmodule

>>> bench/tb.sv
// Testbench top for the I2C master byte engine: stimulus, channel idling and verdict.
`timescale 1ns / 100ps
module tb;
    import i2cm_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 300;
    localparam int RANDOM_ITEMS   = 1070;
    localparam int RANDOM_ROUNDS  = 4;

    // SDA pattern that the slave drives during the data bits of a read
    typedef enum {SDA_RANDOM, SDA_ALL_LOW, SDA_ALL_HIGH} sda_fill_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;

    int          mismatches;
    int          outstanding;
    phase_t      bus_phase;

    // Run knobs for the stimulus, the result-side stall process and the watchdog
    bit          calm;
    int          stalls_asked;
    int          stalls_taken;
    int          stall_left;
    int          quiet_cycles;

    // Slave behavior for the command in flight
    int          ack_after;      // SDA-high poll ticks before the slave acks; negative: never
    int          poll_ticks;
    sda_fill_t   sda_fill;
    int          cur_poll;

    // Run statistics for the closing summary
    int          n_req, n_settings, n_start, n_stop, n_write, n_unacked, n_read, n_ignored;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    i2c_master_byte_engine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    i2cm_bus_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .bus_phase   (bus_phase)
    );

    // Result side: random stall bursts, plus the long hold-off whenever the
    // stimulus asks for one. Exactly one assignment to m_ready per falling edge.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stalls_taken < stalls_asked) begin
                // hold results back long enough for the engine to fill and push back
                stalls_taken++;
                stall_left = LONG_STALL - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one request, with an occasional idle burst in front of it, and
    // hold it until accepted. Returns on the falling edge after acceptance.
    task automatic offer_tick(in_t req);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        n_req++;
        @(negedge aclk);
    endtask

    // Build one bus tick: the command field plus the SDA level the slave
    // would present in the current phase of the engine.
    task automatic drive_tick(logic [2:0] op, logic [7:0] txb);
        in_t req;
        req.op      = op;
        req.tx_byte = txb;
        if (bus_phase == PH_ACK_POLL) begin
            req.sda_in = (ack_after >= 0 && poll_ticks >= ack_after) ? 1'b0 : 1'b1;
            poll_ticks++;
        end else begin
            case (sda_fill)
                SDA_ALL_LOW:  req.sda_in = 1'b0;
                SDA_ALL_HIGH: req.sda_in = 1'b1;
                default:      req.sda_in = 1'($urandom_range(0, 1));
            endcase
        end
        offer_tick(req);
    endtask

    // Issue one command from idle and clock the engine until it is idle again.
    // Ticks in between carry random commands now and then; the engine must drop them.
    task automatic run_command(logic [2:0] op, logic [7:0] txb, int ack_delay,
                               sda_fill_t fill);
        logic [2:0] noise_op;
        logic [7:0] noise_byte;
        ack_after  = ack_delay;
        poll_ticks = 0;
        sda_fill   = fill;
        case (op)
            OP_START: n_start++;
            OP_STOP:  n_stop++;
            OP_WRITE: begin
                n_write++;
                if (ack_delay < 0 || ack_delay > cur_poll) n_unacked++;
            end
            OP_READ_ACK, OP_READ_NACK: n_read++;
            default: n_ignored++;
        endcase
        drive_tick(op, txb);
        while (bus_phase != PH_IDLE) begin
            noise_byte = 8'($urandom);
            if ($urandom_range(0, 3) == 0) noise_op = 3'($urandom_range(0, 7));
            else noise_op = OP_NONE;
            drive_tick(noise_op, noise_byte);
        end
    endtask

    // Write a register with the engine idle and every result drained.
    task automatic write_reg(logic idx, logic [15:0] val);
        while (bus_phase != PH_IDLE) drive_tick(OP_NONE, 8'h00);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        // let the two pipeline stages settle before touching the register
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ACK_POLL_LIMIT) cur_poll = val[POLL_W-1:0];
        n_settings++;
    endtask

    // Mostly acks within the limit, some right at the limit or one past it,
    // and some that never come.
    function automatic int pick_ack_delay();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return $urandom_range(0, cur_poll);
        if (roll < 8) return cur_poll + $urandom_range(0, 1);
        return -1;
    endfunction

    function automatic sda_fill_t pick_fill();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return SDA_ALL_LOW;
        if (roll == 1) return SDA_ALL_HIGH;
        return SDA_RANDOM;
    endfunction

    // One bus transfer: start, address byte, a few data bytes, stop. A fifth
    // of the time issue a lone random command instead, unknown codes included.
    task automatic random_transfer();
        int         n_data;
        logic [2:0] solo_op;
        if ($urandom_range(0, 4) != 0) begin
            run_command(OP_START, 8'($urandom), -1, SDA_RANDOM);
            run_command(OP_WRITE, 8'($urandom), pick_ack_delay(), SDA_RANDOM);
            n_data = $urandom_range(1, 3);
            repeat (n_data) begin
                case ($urandom_range(0, 2))
                    0:       run_command(OP_WRITE, 8'($urandom), pick_ack_delay(),
                                         SDA_RANDOM);
                    1:       run_command(OP_READ_ACK, 8'($urandom), -1, pick_fill());
                    default: run_command(OP_READ_NACK, 8'($urandom), -1, pick_fill());
                endcase
            end
            run_command(OP_STOP, 8'($urandom), -1, SDA_RANDOM);
        end else begin
            solo_op = 3'($urandom_range(0, 7));
            run_command(solo_op, 8'($urandom), pick_ack_delay(), pick_fill());
        end
    endtask

    initial begin
        int round_base;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_TICKS_PER_UNIT;
        cfg_wdata = '0;
        calm      = 1'b0;
        cur_poll  = ACK_POLL_LIMIT_RST;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: idle and unknown codes leave the lines released.
        run_command(OP_NONE, 8'hFF, -1, SDA_RANDOM);
        run_command(3'd6, 8'h00, -1, SDA_RANDOM);
        run_command(3'd7, 8'hFF, -1, SDA_RANDOM);

        // Fastest timing, poll limit of one.
        write_reg(CFG_TICKS_PER_UNIT, 16'd1);
        write_reg(CFG_ACK_POLL_LIMIT, 16'd1);
        run_command(OP_START, 8'h00, -1, SDA_RANDOM);
        run_command(OP_WRITE, 8'hFF, 0, SDA_RANDOM);
        run_command(OP_WRITE, 8'h00, -1, SDA_RANDOM);
        // ack on the last poll still counts; one poll later is a timeout
        run_command(OP_WRITE, 8'hA5, 1, SDA_RANDOM);
        run_command(OP_WRITE, 8'h3C, 2, SDA_RANDOM);
        // master ACK leaves SDA low until the next command
        run_command(OP_READ_ACK, 8'h00, -1, SDA_ALL_HIGH);
        run_command(OP_READ_NACK, 8'h00, -1, SDA_ALL_LOW);
        run_command(OP_READ_ACK, 8'h00, -1, SDA_RANDOM);
        run_command(OP_STOP, 8'h00, -1, SDA_RANDOM);

        // Zero poll limit: only an ack on the very first poll avoids a timeout.
        write_reg(CFG_ACK_POLL_LIMIT, 16'd0);
        run_command(OP_WRITE, 8'h81, 0, SDA_RANDOM);
        run_command(OP_WRITE, 8'h7E, 1, SDA_RANDOM);

        // Zero ticks per unit behaves as one.
        write_reg(CFG_TICKS_PER_UNIT, 16'd0);
        run_command(OP_START, 8'h00, -1, SDA_RANDOM);
        run_command(OP_READ_NACK, 8'h00, -1, SDA_RANDOM);
        run_command(OP_STOP, 8'h00, -1, SDA_RANDOM);

        // The poll register keeps only its low 10 bits: this write sets limit 1.
        write_reg(CFG_ACK_POLL_LIMIT, 16'hFC01);
        write_reg(CFG_TICKS_PER_UNIT, 16'd1);
        run_command(OP_WRITE, 8'h55, 1, SDA_RANDOM);
        run_command(OP_WRITE, 8'hAA, 2, SDA_RANDOM);

        // Random transfers over a few settings with short units.
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            write_reg(CFG_TICKS_PER_UNIT, (round == 2) ? 16'd2 : 16'd1);
            write_reg(CFG_ACK_POLL_LIMIT, 16'($urandom_range(0, 12)));
            if (round == RANDOM_ROUNDS - 1) calm = 1'b1;
            // first round: hold results off while requests keep coming
            if (round == 0) stalls_asked++;
            round_base = n_req;
            while (n_req - round_base < RANDOM_ITEMS / RANDOM_ROUNDS) begin
                random_transfer();
                // second round: in a window of requests, pause after each transfer until every result is back
                if (round == 1 && n_req - round_base >= RANDOM_ITEMS / 8 &&
                    n_req - round_base < RANDOM_ITEMS / 8 + 200) begin
                    s_valid <= 1'b0;
                    while (outstanding != 0) @(negedge aclk);
                    @(negedge aclk);
                end
            end
        end

        // Drain, then give any stray result time to show up.
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("Covered %0d requests across %0d register writes: %0d starts, %0d stops,",
                 n_req, n_settings, n_start, n_stop);
        $display("%0d writes (%0d left unacknowledged), %0d reads, %0d idle or unknown codes.",
                 n_write, n_unacked, n_read, n_ignored);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
